### design/frc_pkg.sv
// frc_pkg: shared types, codes and constants of the flow counter table
// depends on nothing
`default_nettype none
package frc_pkg;
	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int NUM_EXCLUDED = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED_3 = 3'd4;

	// result status codes
	localparam logic [2:0] ST_COUNTED = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_EXCLUDED = 3'd3;
	localparam logic [2:0] ST_DISABLED = 3'd4;

	// packet class decided by the front end
	localparam logic [1:0] CLS_SCAN = 2'd0;
	localparam logic [1:0] CLS_DISABLED = 2'd1;
	localparam logic [1:0] CLS_EXCLUDED = 2'd2;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [1:0] cls;
	} job_t;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] count;
	} entry_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} queue_out_t;
endpackage
`default_nettype wire

### design/frc_if.sv
// frc_if: valid/ready channels for packet words and result words
// depends on nothing
`default_nettype none
interface frc_in_if;
	logic valid;
	logic ready;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	modport source (output valid, src_ip, dst_ip, src_port, dst_port, input ready);
	modport sink (input valid, src_ip, dst_ip, src_port, dst_port, output ready);
endinterface

interface frc_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [5:0] slot;
	logic [31:0] flow_count;
	modport source (output valid, status, slot, flow_count, input ready);
	modport sink (input valid, status, slot, flow_count, output ready);
endinterface
`default_nettype wire

### design/frc_front.sv
// frc_front: config registers and packet classification
// depends on frc_pkg, frc_if
`default_nettype none
module frc_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [frc_pkg::CFG_DATA_W-1:0] cfg_data,
	frc_in_if.sink in_ch,
	input wire logic q_full,
	output logic push,
	output frc_pkg::job_t push_job
);
	logic enable_q;
	logic [31:0] excl_q [frc_pkg::NUM_EXCLUDED];
	logic excluded;
	logic live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			for (int i = 0; i < frc_pkg::NUM_EXCLUDED; i++) excl_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				frc_pkg::REG_REPORT_ENABLE: enable_q <= cfg_data[0];
				frc_pkg::REG_EXCLUDED_0: excl_q[0] <= cfg_data;
				frc_pkg::REG_EXCLUDED_1: excl_q[1] <= cfg_data;
				frc_pkg::REG_EXCLUDED_2: excl_q[2] <= cfg_data;
				frc_pkg::REG_EXCLUDED_3: excl_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// list ends at the first zero entry
	always_comb begin
		excluded = 1'b0;
		live = 1'b1;
		for (int i = 0; i < frc_pkg::NUM_EXCLUDED; i++) begin
			if (excl_q[i] == 32'd0) live = 1'b0;
			if (live && (in_ch.src_ip == excl_q[i] || in_ch.dst_ip == excl_q[i]))
				excluded = 1'b1;
		end
	end

	assign in_ch.ready = !q_full;
	assign push = in_ch.valid && !q_full;

	always_comb begin
		push_job.src_ip = in_ch.src_ip;
		push_job.dst_ip = in_ch.dst_ip;
		push_job.src_port = in_ch.src_port;
		push_job.dst_port = in_ch.dst_port;
		if (!enable_q) push_job.cls = frc_pkg::CLS_DISABLED;
		else if (excluded) push_job.cls = frc_pkg::CLS_EXCLUDED;
		else push_job.cls = frc_pkg::CLS_SCAN;
	end
endmodule
`default_nettype wire

### design/frc_queue.sv
// frc_queue: two-deep queue of classified packets between front and back
// depends on frc_pkg
`default_nettype none
module frc_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire frc_pkg::job_t push_job,
	output logic full,
	input wire logic pop,
	output frc_pkg::queue_out_t head
);
	frc_pkg::job_t store_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	assign full = (cnt_q == 2'd2);
	assign head.valid = (cnt_q != 2'd0);
	assign head.job = store_q[rd_ptr_q];
endmodule
`default_nettype wire

### design/frc_back.sv
// frc_back: table memory, scan sequencer and result register
// depends on frc_pkg, frc_if
`default_nettype none
module frc_back #(
	parameter int TABLE_DEPTH = frc_pkg::DEFAULT_TABLE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire frc_pkg::queue_out_t head,
	output logic pop,
	frc_out_if.source out_ch
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD = 2'd1;
	localparam logic [1:0] S_EV = 2'd2;

	frc_pkg::entry_t mem [TABLE_DEPTH];
	frc_pkg::entry_t rdata_q, entry, wdata;
	frc_pkg::job_t job_q;
	logic [1:0] state_q;
	logic [IW-1:0] k_q;
	logic [FW-1:0] fill_q;
	logic virt_q;
	logic out_valid_q;
	logic [2:0] status_q;
	logic [5:0] slot_q;
	logic [31:0] count_q;
	logic out_free, rd_en, hit, free, wr_en, at_fill, res_load;
	logic [31:0] new_count;

	assign out_free = !out_valid_q || out_ch.ready;
	assign pop = (state_q == S_IDLE) && head.valid && out_free;
	assign at_fill = (FW'(k_q) == fill_q);
	assign rd_en = (state_q == S_RD) && !at_fill;

	// the entry at the fill mark is not read from memory but taken as free (all zero)
	assign entry = virt_q ? '0 : rdata_q;
	assign hit = entry.src_ip == job_q.src_ip && entry.dst_ip == job_q.dst_ip &&
		entry.src_port == job_q.src_port && entry.dst_port == job_q.dst_port;
	assign free = (entry.src_ip == 32'd0);
	assign new_count = hit ? ((entry.count == 32'hFFFF_FFFF) ? entry.count
		: entry.count + 32'd1) : 32'd1;
	assign wr_en = (state_q == S_EV) && (hit || free);

	// a result word is loaded for a skipped packet or at the end of a scan
	assign res_load = (pop && head.job.cls != frc_pkg::CLS_SCAN) ||
		((state_q == S_EV) && (hit || free || k_q == IW'(TABLE_DEPTH - 1)));

	always_comb begin
		wdata.src_ip = job_q.src_ip;
		wdata.dst_ip = job_q.dst_ip;
		wdata.src_port = job_q.src_port;
		wdata.dst_port = job_q.dst_port;
		wdata.count = new_count;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[k_q] <= wdata;
		if (rd_en) rdata_q <= mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= head.job;
		if (state_q == S_RD) virt_q <= at_fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
			status_q <= frc_pkg::ST_COUNTED;
			slot_q <= '0;
			count_q <= '0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						k_q <= '0;
						if (head.job.cls == frc_pkg::CLS_SCAN) begin
							state_q <= S_RD;
						end else begin
							status_q <= (head.job.cls == frc_pkg::CLS_DISABLED)
								? frc_pkg::ST_DISABLED : frc_pkg::ST_EXCLUDED;
							slot_q <= '0;
							count_q <= '0;
						end
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (hit || free) begin
						if (virt_q) fill_q <= fill_q + FW'(1);
						status_q <= hit ? frc_pkg::ST_COUNTED : frc_pkg::ST_INSERTED;
						slot_q <= 6'(k_q);
						count_q <= new_count;
						state_q <= S_IDLE;
					end else if (k_q == IW'(TABLE_DEPTH - 1)) begin
						status_q <= frc_pkg::ST_FULL;
						slot_q <= '0;
						count_q <= '0;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + IW'(1);
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = status_q;
	assign out_ch.slot = slot_q;
	assign out_ch.flow_count = count_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(TABLE_DEPTH)) else $error("fill mark past table end");
	a_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> FW'(k_q) <= fill_q)
		else $error("scan beyond fill mark");
	a_ev_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EV |-> $past(state_q) == S_RD) else $error("evaluate without read");
	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EV && (hit || free) |-> !out_valid_q)
		else $error("result register busy at scan end");
endmodule
`default_nettype wire

### design/flow_report_counter_table_top.sv
// flow_report_counter_table_top: per-flow packet counter with exclusion list
// depends on frc_pkg, frc_if, frc_front, frc_queue, frc_back
//
// channel  dir  handshake      word
// in_ch    in   valid/ready    src_ip, dst_ip, src_port, dst_port
// out_ch   out  valid/ready    status, slot, flow_count
// cfg      in   cfg_we only    cfg_index, cfg_data
//
// a skipped packet has its result word loaded when it is popped; a scanned packet
// walks the table from slot 0 until a hit, a free entry or the last slot (table full),
// one memory read then one compare per entry on the single table port
// reset clears config and marks the whole table free at once via a fill mark
// a two-word queue lets packets be taken while the back end scans or a result waits
`default_nettype none
module flow_report_counter_table_top #(
	parameter int TABLE_DEPTH = frc_pkg::DEFAULT_TABLE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [frc_pkg::CFG_DATA_W-1:0] cfg_data,
	frc_in_if.sink in_ch,
	frc_out_if.source out_ch
);
	// front to queue
	logic push, q_full, pop;
	frc_pkg::job_t push_job;
	// queue to back
	frc_pkg::queue_out_t head;

	frc_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_ch, .q_full, .push, .push_job
	);

	frc_queue u_queue (
		.clk, .arst_n, .push, .push_job, .full(q_full), .pop, .head
	);

	frc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n, .head, .pop, .out_ch
	);
endmodule
`default_nettype wire
